// ----- sv/tcw_pkg.sv -----
package tcw_pkg;

    localparam int COLUMNS_DEFAULT   = 80;
    localparam int ROWS_DEFAULT      = 25;
    localparam int TAB_WIDTH_DEFAULT = 8;

    localparam int COL_OUT_W = 7;
    localparam int ROW_OUT_W = 5;
    localparam int POS_W     = 11;
    localparam int CELL_W    = 16;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_command;

    localparam logic REG_TEXT_ATTR  = 1'b0;
    localparam logic REG_CLEAR_ATTR = 1'b1;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_LAST = 8'h7F;

    localparam logic [ATTR_W-1:0] ATTR_TEXT_RESET  = 8'h0F;
    localparam logic [ATTR_W-1:0] ATTR_CLEAR_RESET = 8'h07;
    localparam logic [CELL_W-1:0] CELL_RESET       = 16'h0720;

    typedef struct packed {
        logic store;
        logic scroll;
    } t_put_flags;

endpackage

// ----- sv/tcw_cursor.sv -----
module tcw_cursor #(
    parameter int COLUMNS   = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS      = tcw_pkg::ROWS_DEFAULT,
    parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEFAULT
) (
    input  logic [$clog2(COLUMNS)-1:0]   i_col,
    input  logic [$clog2(ROWS)-1:0]      i_row,
    input  logic [$clog2(TAB_WIDTH)-1:0] i_phase,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_char,
    output logic [$clog2(COLUMNS)-1:0]   o_col,
    output logic [$clog2(ROWS)-1:0]      o_row,
    output logic [$clog2(TAB_WIDTH)-1:0] o_phase,
    output tcw_pkg::t_put_flags          o_flags
);
    import tcw_pkg::*;

    localparam int CW  = $clog2(COLUMNS);
    localparam int EW  = $clog2(COLUMNS + TAB_WIDTH);
    localparam int RW  = $clog2(ROWS);
    localparam int RNW = $clog2(ROWS + 1);
    localparam int PW  = $clog2(TAB_WIDTH);

    logic [EW-1:0]  w_col;
    logic [RNW-1:0] w_row;
    logic [PW-1:0]  w_phase;
    logic           w_store;
    logic           w_scroll;

    // The phase is the column modulo the tab width, tracked alongside the column.
    always_comb begin
        w_col    = EW'(i_col);
        w_row    = RNW'(i_row);
        w_phase  = i_phase;
        w_store  = 1'b0;
        w_scroll = 1'b0;
        case (i_char)
            CH_BACKSPACE: begin
                if (i_col != '0) begin
                    w_col   = EW'(i_col) - EW'(1);
                    w_phase = (i_phase == '0) ? PW'(TAB_WIDTH - 1) : i_phase - PW'(1);
                end
            end
            CH_TAB: begin
                w_col   = EW'(i_col) + EW'(TAB_WIDTH) - EW'(i_phase);
                w_phase = '0;
            end
            CH_CR: begin
                w_col   = '0;
                w_phase = '0;
            end
            CH_LF: begin
                w_col   = '0;
                w_row   = RNW'(i_row) + RNW'(1);
                w_phase = '0;
            end
            default: begin
                if (i_char inside {[CH_SPACE:CH_PRINT_LAST]}) begin
                    w_store = 1'b1;
                    w_col   = EW'(i_col) + EW'(1);
                    w_phase = (i_phase == PW'(TAB_WIDTH - 1)) ? '0 : i_phase + PW'(1);
                end
            end
        endcase
        if (w_col >= EW'(COLUMNS)) begin
            w_col   = '0;
            w_row   = w_row + RNW'(1);
            w_phase = '0;
        end
        if (w_row == RNW'(ROWS)) begin
            w_row    = RNW'(ROWS - 1);
            w_scroll = 1'b1;
        end
    end

    assign o_col          = CW'(w_col);
    assign o_row          = RW'(w_row);
    assign o_phase        = w_phase;
    assign o_flags.store  = w_store;
    assign o_flags.scroll = w_scroll;

endmodule

// ----- sv/text_console_writer.sv -----
// Channel   Direction  Handshake             Payload
// command   in         start high, busy low  i_command, i_character, i_cell_address
// result    out        o_done, one cycle     o_cursor_column, o_cursor_row,
//                                            o_cursor_position, o_cell_data, o_scrolled
// config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// Put character without scroll and the unused command: o_done in the cycle after start.
// Read cell: the memory read is registered first, then S_READ registers the cell data and raises o_done.
// Clear screen: one cell write per cycle through the single write port, over all COLUMNS*ROWS cells.
// Put character with scroll: one cell copied or blanked per cycle, over all COLUMNS*ROWS cells.
// After reset a clearing pass over all cells holds busy high; config is still taken.
// The receiver cannot stall: o_done marks each result for exactly one cycle.
module text_console_writer #(
    parameter int COLUMNS   = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS      = tcw_pkg::ROWS_DEFAULT,
    parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tcw_pkg::t_command             i_command,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_character,
    input  logic [tcw_pkg::POS_W-1:0]     i_cell_address,
    output logic                          o_done,
    output logic [tcw_pkg::COL_OUT_W-1:0] o_cursor_column,
    output logic [tcw_pkg::ROW_OUT_W-1:0] o_cursor_row,
    output logic [tcw_pkg::POS_W-1:0]     o_cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]    o_cell_data,
    output logic                          o_scrolled,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int PW    = $clog2(TAB_WIDTH);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_FILL
    } t_state;

    t_state            r_state;
    logic [AW-1:0]     r_idx;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [PW-1:0]     r_phase;
    logic              r_done;
    logic              r_scrolled;
    logic [CELL_W-1:0] r_cell_data;
    logic [CELL_W-1:0] r_fill;
    logic              r_addr_ok;
    logic [ATTR_W-1:0] r_text_attr;
    logic [ATTR_W-1:0] r_clear_attr;

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rd_data;

    logic [CW-1:0]     n_col;
    logic [RW-1:0]     n_row;
    logic [PW-1:0]     n_phase;
    t_put_flags        w_flags;
    logic [AW-1:0]     w_pos;
    logic              w_addr_ok;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic              w_re;
    logic [AW-1:0]     w_raddr;

    tcw_cursor #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_cursor (
        .i_col   (r_col),
        .i_row   (r_row),
        .i_phase (r_phase),
        .i_char  (i_character),
        .o_col   (n_col),
        .o_row   (n_row),
        .o_phase (n_phase),
        .o_flags (w_flags)
    );

    assign w_pos     = AW'(AW'(r_row) * AW'(COLUMNS) + AW'(r_col));
    assign w_addr_ok = (32'(i_cell_address) < 32'(CELLS));

    // Memory port control. During a scroll the read runs one cell ahead of the
    // write, COLUMNS cells further on, so every read sees data not yet moved.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_fill;
        w_re    = 1'b0;
        w_raddr = r_idx + AW'(COLUMNS + 1);
        case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_wdata = CELL_RESET;
            end
            S_IDLE: begin
                if (start) begin
                    case (i_command)
                        CMD_PUT: begin
                            w_we    = w_flags.store;
                            w_waddr = w_pos;
                            w_wdata = {r_text_attr, i_character};
                            w_re    = w_flags.scroll;
                            w_raddr = AW'(COLUMNS);
                        end
                        CMD_READ: begin
                            w_re    = w_addr_ok;
                            w_raddr = AW'(i_cell_address);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCROLL: begin
                w_we    = 1'b1;
                w_wdata = r_rd_data;
                w_re    = (r_idx != AW'(CELLS - COLUMNS - 1));
            end
            S_FILL: begin
                w_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_idx        <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_phase      <= '0;
            r_done       <= 1'b0;
            r_scrolled   <= 1'b0;
            r_text_attr  <= ATTR_TEXT_RESET;
            r_clear_attr <= ATTR_CLEAR_RESET;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TEXT_ATTR:  r_text_attr  <= i_cfg_data;
                    REG_CLEAR_ATTR: r_clear_attr <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_INIT: begin
                    if (r_idx == AW'(CELLS - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_cell_data <= '0;
                        r_scrolled  <= 1'b0;
                        case (i_command)
                            CMD_PUT: begin
                                r_col   <= n_col;
                                r_row   <= n_row;
                                r_phase <= n_phase;
                                if (w_flags.scroll) begin
                                    r_idx      <= '0;
                                    r_scrolled <= 1'b1;
                                    r_state    <= S_SCROLL;
                                end else begin
                                    r_done <= 1'b1;
                                end
                            end
                            CMD_READ: begin
                                r_addr_ok <= w_addr_ok;
                                r_state   <= S_READ;
                            end
                            CMD_CLEAR: begin
                                r_fill  <= {r_clear_attr, CH_SPACE};
                                r_idx   <= '0;
                                r_state <= S_FILL;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_cell_data <= r_addr_ok ? r_rd_data : '0;
                    r_done      <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_SCROLL: begin
                    if (r_idx == AW'(CELLS - COLUMNS - 1)) begin
                        r_idx   <= AW'(CELLS - COLUMNS);
                        r_fill  <= {r_text_attr, CH_SPACE};
                        r_state <= S_FILL;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_FILL: begin
                    if (r_idx == AW'(CELLS - 1)) begin
                        r_idx   <= '0;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_cursor_column   = COL_OUT_W'(r_col);
    assign o_cursor_row      = ROW_OUT_W'(r_row);
    assign o_cursor_position = POS_W'(w_pos);
    assign o_cell_data       = r_cell_data;
    assign o_scrolled        = r_scrolled;

`ifndef NO_ASSERTIONS
    a_put_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_PUT && !w_flags.scroll) |=> o_done)
        else $error("put character without scroll did not finish in one cycle");

    a_read_two_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_READ) |-> ##2 o_done)
        else $error("read cell did not finish in two cycles");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_row) < 32'(ROWS)) && (32'(r_col) < 32'(COLUMNS)))
        else $error("cursor outside the screen");

    a_scroll_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_scrolled) |-> (r_row == RW'(ROWS - 1)))
        else $error("scroll reported with cursor not on the last row");
`endif

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
    import tcw_pkg::*;

    localparam int COLS        = COLUMNS_DEFAULT;
    localparam int ROWS        = ROWS_DEFAULT;
    localparam int TAB         = TAB_WIDTH_DEFAULT;
    localparam int CELLS       = COLS * ROWS;
    // Clear and scroll walk every cell, so they make the longest quiet stretches.
    localparam int STALL_LIMIT = 10 * CELLS;
    // Clear and scroll cost a full screen pass each, so their number is capped.
    localparam int HEAVY_BUDGET = 150;

    typedef struct packed {
        logic [COL_OUT_W-1:0] column;
        logic [ROW_OUT_W-1:0] row;
        logic [POS_W-1:0]     position;
        logic [CELL_W-1:0]    cell_data;
        logic                 scrolled;
    } t_console_result;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 start          = 1'b0;
    logic                 busy;
    t_command             i_command      = CMD_NOP;
    logic [CHAR_W-1:0]    i_character    = '0;
    logic [POS_W-1:0]     i_cell_address = '0;
    logic                 o_done;
    logic [COL_OUT_W-1:0] o_cursor_column;
    logic [ROW_OUT_W-1:0] o_cursor_row;
    logic [POS_W-1:0]     o_cursor_position;
    logic [CELL_W-1:0]    o_cell_data;
    logic                 o_scrolled;
    logic                 i_cfg_we       = 1'b0;
    logic                 i_cfg_idx      = 1'b0;
    logic [ATTR_W-1:0]    i_cfg_data     = '0;

    // Shadow copy of the console state.
    logic [CELL_W-1:0]    screen_model [CELLS];
    int                   cur_col;
    int                   cur_row;
    logic [ATTR_W-1:0]    text_attr_model;
    logic [ATTR_W-1:0]    clear_attr_model;

    t_console_result      pending_results [$];
    int                   error_count   = 0;
    int                   items_sent    = 0;
    int                   results_seen  = 0;
    int                   heavy_left    = HEAVY_BUDGET;
    int                   stall_cycles  = 0;
    int                   idle_percent  = 0;

    always #6 i_clk = ~i_clk;

    text_console_writer i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_command         (i_command),
        .i_character       (i_character),
        .i_cell_address    (i_cell_address),
        .o_done            (o_done),
        .o_cursor_column   (o_cursor_column),
        .o_cursor_row      (o_cursor_row),
        .o_cursor_position (o_cursor_position),
        .o_cell_data       (o_cell_data),
        .o_scrolled        (o_scrolled),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    function automatic t_console_result predict_console(t_command cmd, logic [CHAR_W-1:0] ch,
                                                        logic [POS_W-1:0] addr);
        t_console_result r;
        int              k;
        r = '0;
        case (cmd)
            CMD_PUT: begin
                if (ch == CH_BACKSPACE) begin
                    if (cur_col > 0)
                        cur_col--;
                end else if (ch == CH_TAB) begin
                    cur_col = cur_col + TAB - (cur_col % TAB);
                end else if (ch == CH_CR) begin
                    cur_col = 0;
                end else if (ch == CH_LF) begin
                    cur_col = 0;
                    cur_row++;
                end else if (ch >= CH_SPACE && ch <= CH_PRINT_LAST) begin
                    screen_model[cur_row * COLS + cur_col] = {text_attr_model, ch};
                    cur_col++;
                end
                if (cur_col >= COLS) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS) begin
                    for (k = 0; k < CELLS - COLS; k++)
                        screen_model[k] = screen_model[k + COLS];
                    for (k = CELLS - COLS; k < CELLS; k++)
                        screen_model[k] = {text_attr_model, CH_SPACE};
                    cur_row    = ROWS - 1;
                    r.scrolled = 1'b1;
                end
            end
            CMD_READ: begin
                if (addr < CELLS)
                    r.cell_data = screen_model[addr];
            end
            CMD_CLEAR: begin
                for (k = 0; k < CELLS; k++)
                    screen_model[k] = {clear_attr_model, CH_SPACE};
            end
            default: ;
        endcase
        r.column   = COL_OUT_W'(cur_col);
        r.row      = ROW_OUT_W'(cur_row);
        r.position = POS_W'(cur_row * COLS + cur_col);
        return r;
    endfunction

    // True when putting this byte at the current cursor would scroll the screen.
    function automatic bit put_scrolls(logic [CHAR_W-1:0] ch);
        if (cur_row != ROWS - 1)
            return 1'b0;
        if (ch == CH_LF)
            return 1'b1;
        if (ch == CH_TAB)
            return (cur_col + TAB - (cur_col % TAB)) >= COLS;
        if (ch >= CH_SPACE && ch <= CH_PRINT_LAST)
            return cur_col == COLS - 1;
        return 1'b0;
    endfunction

    task automatic report_error(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what, got, want);
        error_count++;
    endtask

    task automatic send_item(t_command cmd, logic [CHAR_W-1:0] ch, logic [POS_W-1:0] addr);
        t_console_result want;
        int              gap;
        if (cmd == CMD_PUT && heavy_left <= 0 && put_scrolls(ch))
            ch = CH_CR;
        if (cmd == CMD_CLEAR && heavy_left <= 0)
            cmd = CMD_NOP;
        @(negedge i_clk);
        start          <= 1'b1;
        i_command      <= cmd;
        i_character    <= ch;
        i_cell_address <= addr;
        do
            @(posedge i_clk);
        while (busy);
        want = predict_console(cmd, ch, addr);
        if (want.scrolled || cmd == CMD_CLEAR)
            heavy_left--;
        pending_results.push_back(want);
        items_sent++;
        if ($urandom_range(0, 99) < idle_percent) begin
            gap = $urandom_range(1, 3);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drops start and waits until every command has reported and the block is free.
    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(negedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [ATTR_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == REG_TEXT_ATTR)
            text_attr_model = value;
        else
            clear_attr_model = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_attributes(logic [ATTR_W-1:0] text_attr, logic [ATTR_W-1:0] clear_attr);
        wait_idle();
        write_register(REG_TEXT_ATTR, text_attr);
        write_register(REG_CLEAR_ATTR, clear_attr);
    endtask

    task automatic test_reset_contents();
        set_attributes(ATTR_TEXT_RESET, ATTR_CLEAR_RESET);
        send_item(CMD_READ, 8'h00, POS_W'(0));
        send_item(CMD_READ, 8'hFF, POS_W'(CELLS - 1));
        send_item(CMD_READ, 8'h55, POS_W'(CELLS));
        send_item(CMD_READ, 8'hAA, '1);
    endtask

    task automatic test_put_character();
        set_attributes(8'hFF, 8'h00);
        send_item(CMD_PUT, 8'h41, '1);
        send_item(CMD_PUT, CH_SPACE, '0);
        send_item(CMD_PUT, CH_PRINT_LAST, POS_W'(CELLS));
        // Bytes outside the printable range leave the screen and the cursor alone.
        send_item(CMD_PUT, 8'h80, '0);
        send_item(CMD_PUT, 8'hFF, '0);
        send_item(CMD_PUT, 8'h00, '0);
        send_item(CMD_PUT, 8'h1F, '0);
        send_item(CMD_PUT, CH_BACKSPACE, '0);
        send_item(CMD_PUT, CH_TAB, '0);
        send_item(CMD_PUT, CH_CR, '0);
        send_item(CMD_PUT, CH_BACKSPACE, '0);
        send_item(CMD_PUT, CH_TAB, '0);
        send_item(CMD_PUT, CH_TAB, '0);
        send_item(CMD_PUT, CH_LF, '0);
        send_item(CMD_READ, 8'h00, POS_W'(0));
        send_item(CMD_READ, 8'h00, POS_W'(1));
        send_item(CMD_READ, 8'h00, POS_W'(2));
    endtask

    task automatic test_other_commands();
        set_attributes(8'h00, 8'hFF);
        send_item(CMD_NOP, 8'hFF, '1);
        // Clear must leave the cursor where the line feed put it.
        send_item(CMD_CLEAR, 8'h41, POS_W'(5));
        send_item(CMD_READ, 8'h00, POS_W'(0));
        send_item(CMD_READ, 8'h00, POS_W'(CELLS - 1));
        send_item(CMD_PUT, 8'h7A, '0);
        send_item(CMD_READ, 8'h00, POS_W'(COLS));
    endtask

    task automatic test_random_text(logic [ATTR_W-1:0] text_attr, logic [ATTR_W-1:0] clear_attr,
                                    int count, int idle_pct);
        int target;
        int pick;
        int pos;
        set_attributes(text_attr, clear_attr);
        idle_percent = idle_pct;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                repeat ($urandom_range(1, 12))
                    send_item(CMD_PUT, CHAR_W'($urandom_range(CH_SPACE, CH_PRINT_LAST)),
                              POS_W'($urandom));
                send_item(CMD_PUT, CH_SPACE, POS_W'($urandom));
            end else if (pick < 66) begin
                send_item(CMD_PUT, CH_LF, POS_W'($urandom));
            end else if (pick < 70) begin
                send_item(CMD_PUT, CH_CR, POS_W'($urandom));
            end else if (pick < 75) begin
                send_item(CMD_PUT, CH_TAB, POS_W'($urandom));
            end else if (pick < 79) begin
                repeat ($urandom_range(1, 3))
                    send_item(CMD_PUT, CH_BACKSPACE, POS_W'($urandom));
            end else if (pick < 89) begin
                // Read back what was just typed.
                repeat ($urandom_range(1, 3)) begin
                    pos = cur_row * COLS + cur_col - int'($urandom_range(0, 10));
                    if (pos < 0)
                        pos = 0;
                    send_item(CMD_READ, CHAR_W'($urandom), POS_W'(pos));
                end
            end else if (pick < 94) begin
                send_item(CMD_PUT, CHAR_W'($urandom), POS_W'($urandom));
            end else if (pick < 96) begin
                send_item(CMD_NOP, CHAR_W'($urandom), POS_W'($urandom));
            end else if (pick < 99) begin
                send_item(CMD_READ, CHAR_W'($urandom), POS_W'($urandom));
            end else begin
                send_item(CMD_CLEAR, CHAR_W'($urandom), POS_W'($urandom));
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_console_result want;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_error("result with nothing pending", 32'(o_cursor_position), 32'(0));
            end else begin
                want = pending_results.pop_front();
                if (o_cursor_column !== want.column)
                    report_error("cursor_column", 32'(o_cursor_column), 32'(want.column));
                if (o_cursor_row !== want.row)
                    report_error("cursor_row", 32'(o_cursor_row), 32'(want.row));
                if (o_cursor_position !== want.position)
                    report_error("cursor_position", 32'(o_cursor_position),
                                 32'(want.position));
                if (o_cell_data !== want.cell_data)
                    report_error("cell_data", 32'(o_cell_data), 32'(want.cell_data));
                if (o_scrolled !== want.scrolled)
                    report_error("scrolled", 32'(o_scrolled), 32'(want.scrolled));
            end
        end
    end

    // Counts cycles in which no transfer happens on either side.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int k;
        for (k = 0; k < CELLS; k++)
            screen_model[k] = CELL_RESET;
        cur_col          = 0;
        cur_row          = 0;
        text_attr_model  = ATTR_TEXT_RESET;
        clear_attr_model = ATTR_CLEAR_RESET;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_contents();
        test_put_character();
        test_other_commands();
        test_random_text(ATTR_TEXT_RESET, ATTR_CLEAR_RESET, 360, 25);
        test_random_text(8'hFF, 8'h00, 360, 40);
        test_random_text(8'h00, 8'hFF, 360, 10);
        test_random_text(ATTR_W'($urandom), ATTR_W'($urandom), 360, 30);
        test_random_text(ATTR_W'($urandom), ATTR_W'($urandom), 360, 0);

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
